// File: src/mat_pkg.sv
// shared types, constants and helpers of the matrix add / transpose / multiply engine
// depends on nothing; every other file but mat_ram refers to it by scoped names
`default_nettype none

package mat_pkg;

	localparam int DATA_W      = 32;
	localparam int IDX_W       = 3;
	localparam int DIM_W       = 4;
	localparam int MAX_DIM_DEF = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 4;
	localparam int JOB_DEPTH   = 2;
	localparam int OUT_DEPTH   = 4;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE   = 2'd0,
		REG_ROWS_A = 2'd1,
		REG_COLS_A = 2'd2,
		REG_COLS_B = 2'd3
	} cfg_reg_t;

	// mode register codes
	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_MUL = 2'd1;
	localparam logic [1:0] MODE_TRN = 2'd2;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_MUL = 2'd1,
		OP_TRN = 2'd2
	} op_t;

	// one loaded problem handed from the front to the back
	typedef struct packed {
		logic              bank;
		op_t               op;
		logic [DIM_W-1:0]  ra;
		logic [DIM_W-1:0]  ca;
		logic [DIM_W-1:0]  cb;
	} job_t;

	// one result beat
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic              last;
	} res_t;

	// unused mode code runs as transpose
	function automatic op_t to_op(input logic [1:0] mode);
		op_t op;
		op = OP_TRN;
		unique case (mode)
			MODE_ADD: op = OP_ADD;
			MODE_MUL: op = OP_MUL;
			default:  op = OP_TRN;
		endcase
		return op;
	endfunction

	// zero counts as one, anything above the limit as the limit
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
			input int maxd);
		logic [DIM_W-1:0] res;
		res = d;
		if (d == '0) begin
			res = DIM_W'(1);
		end else if (int'(d) > maxd) begin
			res = DIM_W'(maxd);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// File: src/mat_in_if.sv
// element stream channel: valid, ready and one signed operand element
// depends on mat_pkg
`default_nettype none

interface mat_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [mat_pkg::DATA_W-1:0]   element;

	modport source (output valid, output element, input ready);
	modport sink   (input valid, input element, output ready);
endinterface

`default_nettype wire

// File: src/mat_out_if.sv
// result stream channel: valid, ready, value with its row, column and last flag
// depends on mat_pkg
`default_nettype none

interface mat_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [mat_pkg::DATA_W-1:0]   value;
	logic [mat_pkg::IDX_W-1:0]           row;
	logic [mat_pkg::IDX_W-1:0]           col;
	logic                                last;

	modport source (output valid, output value, output row, output col, output last,
		input ready);
	modport sink   (input valid, input value, input row, input col, input last,
		output ready);
endinterface

`default_nettype wire

// File: src/mat_cfg_if.sv
// configuration write channel: valid, ready, register index and write data
// depends on mat_pkg
`default_nettype none

interface mat_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [mat_pkg::CFG_IDX_W-1:0]       index;
	logic [mat_pkg::CFG_DATA_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/mat_ram.sv
// generic single write port, single read port ram with registered read data
// no package dependency
`default_nettype none

module mat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: src/mat_job_fifo.sv
// short job queue between the loading front and the computing back
// depends on mat_pkg
`default_nettype none

module mat_job_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mat_pkg::job_t  push_job,
	output      logic           full,
	input  wire logic           pop,
	output      logic           valid,
	output      mat_pkg::job_t  head
);

	localparam int DEPTH = mat_pkg::JOB_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	mat_pkg::job_t    ent_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign valid = (count_q != '0);
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("job pushed into a full queue");
`endif

endmodule

`default_nettype wire

// File: src/mat_front.sv
// front: configuration registers, element intake, operand store writes, job hand-off
// depends on mat_pkg, mat_in_if, mat_cfg_if
`default_nettype none

module mat_front #(
	parameter int MAX_DIM = mat_pkg::MAX_DIM_DEF,
	localparam int SAW = $clog2(2 * MAX_DIM * MAX_DIM)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	mat_in_if.sink                           elem,
	mat_cfg_if.sink                          cfg,
	input  wire logic                        job_full,
	output      logic                        job_push,
	output      mat_pkg::job_t               job,
	output      logic                        a_we,
	output      logic                        b_we,
	output      logic [SAW-1:0]              waddr,
	output      logic [mat_pkg::DATA_W-1:0]  wdata
);

	localparam logic [SAW-1:0] BANK_OFS   = SAW'(MAX_DIM * MAX_DIM);
	localparam logic [SAW-1:0] ROW_STRIDE = SAW'(MAX_DIM);
	localparam int             DW         = mat_pkg::DIM_W;

	logic [1:0]                 mode_q;
	logic [DW-1:0]              rows_a_q;
	logic [DW-1:0]              cols_a_q;
	logic [DW-1:0]              cols_b_q;
	logic                       phase_q;      // 0 loading A, 1 loading B
	logic [mat_pkg::IDX_W-1:0]  r_q;
	logic [mat_pkg::IDX_W-1:0]  c_q;
	logic                       wbank_q;

	mat_pkg::op_t   op;
	logic [DW-1:0]  ra, ca, cb;
	logic [DW-1:0]  rows, cols;
	logic           accept, cfg_wr;
	logic           row_last, col_last, load_done;

	assign op = mat_pkg::to_op(mode_q);
	assign ra = mat_pkg::clamp_dim(rows_a_q, MAX_DIM);
	assign ca = mat_pkg::clamp_dim(cols_a_q, MAX_DIM);
	assign cb = mat_pkg::clamp_dim(cols_b_q, MAX_DIM);

	// shape of the operand being loaded
	always_comb begin
		rows = ra;
		cols = ca;
		if (phase_q && op == mat_pkg::OP_MUL) begin
			rows = ca;
			cols = cb;
		end
	end

	// a configuration beat owns its cycle; no element moves alongside it
	assign cfg.ready  = 1'b1;
	assign cfg_wr     = cfg.valid;
	assign elem.ready = !job_full && !cfg.valid;
	assign accept     = elem.valid && !job_full && !cfg.valid;

	assign col_last  = ({1'b0, c_q} == cols - DW'(1));
	assign row_last  = ({1'b0, r_q} == rows - DW'(1));
	assign load_done = col_last && row_last && (phase_q || op == mat_pkg::OP_TRN);

	assign a_we  = accept && !phase_q;
	assign b_we  = accept && phase_q;
	assign waddr = (wbank_q ? BANK_OFS : '0) + SAW'(r_q) * ROW_STRIDE + SAW'(c_q);
	assign wdata = elem.element;

	assign job_push = accept && load_done;
	assign job      = '{bank: wbank_q, op: op, ra: ra, ca: ca, cb: cb};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= mat_pkg::MODE_ADD;
			rows_a_q <= DW'(1);
			cols_a_q <= DW'(1);
			cols_b_q <= DW'(1);
			phase_q  <= 1'b0;
			r_q      <= '0;
			c_q      <= '0;
			wbank_q  <= 1'b0;
		end else if (cfg_wr) begin
			unique case (mat_pkg::cfg_reg_t'(cfg.index))
				mat_pkg::REG_MODE:   mode_q   <= cfg.data[1:0];
				mat_pkg::REG_ROWS_A: rows_a_q <= cfg.data;
				mat_pkg::REG_COLS_A: cols_a_q <= cfg.data;
				mat_pkg::REG_COLS_B: cols_b_q <= cfg.data;
				default: ;
			endcase
			// any write restarts loading at the first element of A
			phase_q <= 1'b0;
			r_q     <= '0;
			c_q     <= '0;
		end else if (accept) begin
			if (col_last) begin
				c_q <= '0;
				if (row_last) begin
					r_q <= '0;
					if (load_done) begin
						phase_q <= 1'b0;
						wbank_q <= !wbank_q;
					end else begin
						phase_q <= 1'b1;
					end
				end else begin
					r_q <= r_q + mat_pkg::IDX_W'(1);
				end
			end else begin
				c_q <= c_q + mat_pkg::IDX_W'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_b_in_trn: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (op != mat_pkg::OP_TRN))
		else $error("second operand phase entered in transpose mode");
`endif

endmodule

`default_nettype wire

// File: src/mat_back.sv
// back: walks the result matrix, reads operands, multiply / add / accumulate, result queue
// depends on mat_pkg, mat_out_if
`default_nettype none

module mat_back #(
	parameter int MAX_DIM = mat_pkg::MAX_DIM_DEF,
	localparam int SAW = $clog2(2 * MAX_DIM * MAX_DIM)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        job_valid,
	input  wire mat_pkg::job_t               job,
	output      logic                        job_pop,
	output      logic [SAW-1:0]              a_raddr,
	output      logic [SAW-1:0]              b_raddr,
	input  wire logic [mat_pkg::DATA_W-1:0]  a_rdata,
	input  wire logic [mat_pkg::DATA_W-1:0]  b_rdata,
	mat_out_if.source                        res
);

	localparam logic [SAW-1:0] BANK_OFS   = SAW'(MAX_DIM * MAX_DIM);
	localparam logic [SAW-1:0] ROW_STRIDE = SAW'(MAX_DIM);
	localparam int DW    = mat_pkg::DIM_W;
	localparam int IW    = mat_pkg::IDX_W;
	localparam int XW    = mat_pkg::DATA_W;
	localparam int ODEP  = mat_pkg::OUT_DEPTH;
	localparam int OPW   = (ODEP > 1) ? $clog2(ODEP) : 1;
	localparam int OCW   = $clog2(ODEP + 1);

	// walk counters
	logic [IW-1:0]  r_q, c_q, j_q;
	logic [DW-1:0]  rows, cols, terms;
	logic           row_last, col_last, term_last, issue;
	logic [SAW-1:0] bank_ofs;

	// pipeline
	logic              valid_s1, first_s1, final_s1, last_s1;
	mat_pkg::op_t      op_s1;
	logic [IW-1:0]     row_s1, col_s1;
	logic              valid_s2, first_s2, final_s2, last_s2;
	logic [IW-1:0]     row_s2, col_s2;
	logic [XW-1:0]     term_s2;
	logic [XW-1:0]     acc_q;
	logic [XW-1:0]     sum;
	logic [XW-1:0]     term;

	// result queue
	mat_pkg::res_t     oq_q [ODEP];
	logic [OPW-1:0]    owr_q, ord_q;
	logic [OCW-1:0]    ocount_q;
	logic [OCW-1:0]    credit_q;
	logic              opush, opop;
	mat_pkg::res_t     ohead;

	always_comb begin
		rows  = job.ra;
		cols  = job.ca;
		terms = DW'(1);
		unique case (job.op)
			mat_pkg::OP_ADD: begin
				rows = job.ra;
				cols = job.ca;
			end
			mat_pkg::OP_MUL: begin
				rows  = job.ra;
				cols  = job.cb;
				terms = job.ca;
			end
			mat_pkg::OP_TRN: begin
				rows = job.ca;
				cols = job.ra;
			end
			default: ;
		endcase
	end

	assign row_last  = ({1'b0, r_q} == rows - DW'(1));
	assign col_last  = ({1'b0, c_q} == cols - DW'(1));
	assign term_last = ({1'b0, j_q} == terms - DW'(1));
	// one credit per result that may still land in the queue
	assign issue     = job_valid && (credit_q < OCW'(ODEP));
	assign job_pop   = issue && term_last && col_last && row_last;
	assign bank_ofs  = job.bank ? BANK_OFS : '0;

	always_comb begin
		a_raddr = bank_ofs + SAW'(r_q) * ROW_STRIDE + SAW'(c_q);
		b_raddr = bank_ofs + SAW'(r_q) * ROW_STRIDE + SAW'(c_q);
		unique case (job.op)
			mat_pkg::OP_ADD: ;
			mat_pkg::OP_MUL: begin
				a_raddr = bank_ofs + SAW'(r_q) * ROW_STRIDE + SAW'(j_q);
				b_raddr = bank_ofs + SAW'(j_q) * ROW_STRIDE + SAW'(c_q);
			end
			mat_pkg::OP_TRN: begin
				a_raddr = bank_ofs + SAW'(c_q) * ROW_STRIDE + SAW'(r_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			c_q <= '0;
			j_q <= '0;
		end else if (issue) begin
			if (term_last) begin
				j_q <= '0;
				if (col_last) begin
					c_q <= '0;
					r_q <= row_last ? '0 : r_q + IW'(1);
				end else begin
					c_q <= c_q + IW'(1);
				end
			end else begin
				j_q <= j_q + IW'(1);
			end
		end
	end

	// stage 1 tags line up with the registered ram read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s1    <= job.op;
		first_s1 <= (j_q == '0);
		final_s1 <= term_last;
		last_s1  <= term_last && col_last && row_last;
		row_s1   <= r_q;
		col_s1   <= c_q;
	end

	// stage 1 operation, one multiplier
	always_comb begin
		term = a_rdata;
		unique case (op_s1)
			mat_pkg::OP_ADD: term = a_rdata + b_rdata;
			mat_pkg::OP_MUL: term = a_rdata * b_rdata;
			mat_pkg::OP_TRN: term = a_rdata;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		term_s2  <= term;
		first_s2 <= first_s1;
		final_s2 <= final_s1;
		last_s2  <= last_s1;
		row_s2   <= row_s1;
		col_s2   <= col_s1;
	end

	// stage 2 accumulate
	assign sum   = first_s2 ? term_s2 : acc_q + term_s2;
	assign opush = valid_s2 && final_s2;

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			acc_q <= sum;
		end
		if (opush) begin
			oq_q[owr_q] <= '{value: sum, row: row_s2, col: col_s2, last: last_s2};
		end
	end

	assign ohead     = oq_q[ord_q];
	assign res.valid = (ocount_q != '0);
	assign res.value = ohead.value;
	assign res.row   = ohead.row;
	assign res.col   = ohead.col;
	assign res.last  = ohead.last;
	assign opop      = res.valid && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q    <= '0;
			ord_q    <= '0;
			ocount_q <= '0;
			credit_q <= '0;
		end else begin
			if (opush) begin
				owr_q <= (owr_q == OPW'(ODEP - 1)) ? '0 : owr_q + OPW'(1);
			end
			if (opop) begin
				ord_q <= (ord_q == OPW'(ODEP - 1)) ? '0 : ord_q + OPW'(1);
			end
			if (opush && !opop) begin
				ocount_q <= ocount_q + OCW'(1);
			end else if (opop && !opush) begin
				ocount_q <= ocount_q - OCW'(1);
			end
			if ((issue && term_last) && !opop) begin
				credit_q <= credit_q + OCW'(1);
			end else if (opop && !(issue && term_last)) begin
				credit_q <= credit_q - OCW'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_credit_range: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= OCW'(ODEP))
		else $error("result credits above queue depth");
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		opush |-> (ocount_q < OCW'(ODEP)))
		else $error("result pushed into a full queue");
	a_credit_covers: assert property (@(posedge clk) disable iff (!arst_n)
		ocount_q <= credit_q)
		else $error("queued results exceed credits");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid)
		else $error("job released with no job present");
`endif

endmodule

`default_nettype wire

// File: src/matrix_add_transpose_multiply.sv
// one element beat per cycle while loading; add and transpose then give one result per
// cycle, multiply one per cols_a terms (one multiply-accumulate a cycle), while result
// credits last. two operand banks: the next problem loads while the previous one drains;
// intake stalls only for a configuration beat or when both banks hold unfinished problems.
// reset clears control and sets mode add with all dimensions one; operand stores are not
// cleared and need no clearing pass.
// depends on mat_pkg, mat_in_if, mat_out_if, mat_cfg_if, mat_ram, mat_job_fifo,
// mat_front, mat_back
`default_nettype none

module matrix_add_transpose_multiply #(
	parameter int MAX_DIM = mat_pkg::MAX_DIM_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mat_in_if.sink     elem,
	mat_out_if.source  res,
	mat_cfg_if.sink    cfg
);

	// each operand store holds two banks of MAX_DIM x MAX_DIM words
	localparam int SDEPTH = 2 * MAX_DIM * MAX_DIM;
	localparam int SAW    = $clog2(SDEPTH);

	// front to store write side
	logic                        a_we, b_we;
	logic [SAW-1:0]              waddr;
	logic [mat_pkg::DATA_W-1:0]  wdata;

	// back to store read side
	logic [SAW-1:0]              a_raddr, b_raddr;
	logic [mat_pkg::DATA_W-1:0]  a_rdata, b_rdata;

	// job hand-off
	logic           job_push, job_full, job_pop, job_valid;
	mat_pkg::job_t  push_job, head_job;

	// intake, configuration and operand loading
	mat_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.elem     (elem),
		.cfg      (cfg),
		.job_full (job_full),
		.job_push (job_push),
		.job      (push_job),
		.a_we     (a_we),
		.b_we     (b_we),
		.waddr    (waddr),
		.wdata    (wdata)
	);

	// first operand store (A)
	mat_ram #(.WIDTH(mat_pkg::DATA_W), .DEPTH(SDEPTH)) u_store_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	// second operand store (B)
	mat_ram #(.WIDTH(mat_pkg::DATA_W), .DEPTH(SDEPTH)) u_store_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	// one entry per operand bank; a full queue means both banks are taken
	mat_job_fifo u_job_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (push_job),
		.full     (job_full),
		.pop      (job_pop),
		.valid    (job_valid),
		.head     (head_job)
	);

	// result walk, arithmetic and result queue
	mat_back #(.MAX_DIM(MAX_DIM)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (head_job),
		.job_pop   (job_pop),
		.a_raddr   (a_raddr),
		.b_raddr   (b_raddr),
		.a_rdata   (a_rdata),
		.b_rdata   (b_rdata),
		.res       (res)
	);

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps
// self-checking bench for matrix_add_transpose_multiply: streams operand matrices in,
// predicts sums, products and transposes and checks every result beat
// depends on mat_pkg, mat_in_if, mat_out_if, mat_cfg_if and the block itself

module tb;

	localparam int DIM_MAX       = mat_pkg::MAX_DIM_DEF;
	localparam int STORE_SIZE    = DIM_MAX * DIM_MAX;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
	localparam int IDLE_LIMIT    = 3000;   // cycles without any beat before giving up
	localparam int RANDOM_ITEMS  = 110;

	// mode code that the block runs as transpose
	localparam logic [1:0] MODE_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	mat_in_if  elem_ch ();
	mat_out_if res_ch ();
	mat_cfg_if cfg_ch ();

	matrix_add_transpose_multiply DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.elem   (elem_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always #4 clk = ~clk;

	// shadow of the register file and the operand stores
	logic [1:0]  shadow_mode  = mat_pkg::MODE_ADD;
	logic [3:0]  shadow_rows  = 4'd1;
	logic [3:0]  shadow_cols  = 4'd1;
	logic [3:0]  shadow_bcols = 4'd1;
	int          taken        = 0;     // elements loaded into the current problem
	logic [31:0] a_store [STORE_SIZE];
	logic [31:0] b_store [STORE_SIZE];

	mat_pkg::res_t pending_results [$];   // predicted result beats, oldest first

	int   errors    = 0;
	int   hold_count;
	logic hold_req  = 1'b0;            // asks the receiver for one long hold-off
	logic quiet     = 1'b0;            // no idling on either side once set
	int   tx_odds   = 4;               // sender pauses before roughly one item in tx_odds, 0 = never
	int   rx_odds;

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// zero is taken as one, anything past DIM_MAX as DIM_MAX
	function automatic int eff_dim(logic [3:0] d);
		if (d == 4'd0) begin
			return 1;
		end
		if (int'(d) > DIM_MAX) begin
			return DIM_MAX;
		end
		return int'(d);
	endfunction

	function automatic mat_pkg::op_t shadow_op();
		case (shadow_mode)
			mat_pkg::MODE_ADD: begin
				return mat_pkg::OP_ADD;
			end
			mat_pkg::MODE_MUL: begin
				return mat_pkg::OP_MUL;
			end
			default: begin
				return mat_pkg::OP_TRN;     // the spare code falls through to transpose
			end
		endcase
	endfunction

	// operand elements that make up one problem under the current registers
	function automatic int operands_needed();
		int ra, ca, cb;
		ra = eff_dim(shadow_rows);
		ca = eff_dim(shadow_cols);
		cb = eff_dim(shadow_bcols);
		case (shadow_op())
			mat_pkg::OP_ADD: begin
				return 2 * ra * ca;
			end
			mat_pkg::OP_MUL: begin
				return ra * ca + ca * cb;
			end
			default: begin
				return ra * ca;
			end
		endcase
	endfunction

	// every register write restarts loading with the first element of A
	function automatic void apply_reg(mat_pkg::cfg_reg_t idx, logic [3:0] val);
		case (idx)
			mat_pkg::REG_MODE: begin
				shadow_mode = val[1:0];
			end
			mat_pkg::REG_ROWS_A: begin
				shadow_rows = val;
			end
			mat_pkg::REG_COLS_A: begin
				shadow_cols = val;
			end
			default: begin
				shadow_bcols = val;
			end
		endcase
		taken = 0;
	endfunction

	// load one element; the final operand element queues the whole result matrix
	function automatic void absorb_element(logic [31:0] x);
		int            ra, ca, cb, na, total, bcols, b, r, c, j;
		logic [31:0]   acc;
		logic [31:0]   prod;
		mat_pkg::res_t beat;
		ra    = eff_dim(shadow_rows);
		ca    = eff_dim(shadow_cols);
		cb    = eff_dim(shadow_bcols);
		na    = ra * ca;
		total = operands_needed();
		bcols = (shadow_op() == mat_pkg::OP_MUL) ? cb : ca;
		if (taken >= total) begin
			taken = 0;
		end
		if (taken < na) begin
			a_store[(taken / ca) * DIM_MAX + taken % ca] = x;
		end else begin
			b = taken - na;
			b_store[(b / bcols) * DIM_MAX + b % bcols] = x;
		end
		taken++;
		if (taken < total) begin
			return;
		end
		taken = 0;
		case (shadow_op())
			mat_pkg::OP_ADD: begin
				for (r = 0; r < ra; r++) begin
					for (c = 0; c < ca; c++) begin
						beat.value = a_store[r * DIM_MAX + c] + b_store[r * DIM_MAX + c];
						beat.row   = 3'(r);
						beat.col   = 3'(c);
						beat.last  = (r == ra - 1) && (c == ca - 1);
						pending_results.push_back(beat);
					end
				end
			end
			mat_pkg::OP_MUL: begin
				for (r = 0; r < ra; r++) begin
					for (c = 0; c < cb; c++) begin
						acc = '0;
						for (j = 0; j < ca; j++) begin
							// low word of the product is the same signed or unsigned
							prod = a_store[r * DIM_MAX + j] * b_store[j * DIM_MAX + c];
							acc  = acc + prod;
						end
						beat.value = acc;
						beat.row   = 3'(r);
						beat.col   = 3'(c);
						beat.last  = (r == ra - 1) && (c == cb - 1);
						pending_results.push_back(beat);
					end
				end
			end
			default: begin
				// result is cols_a by rows_a
				for (r = 0; r < ca; r++) begin
					for (c = 0; c < ra; c++) begin
						beat.value = a_store[c * DIM_MAX + r];
						beat.row   = 3'(r);
						beat.col   = 3'(c);
						beat.last  = (r == ca - 1) && (c == ra - 1);
						pending_results.push_back(beat);
					end
				end
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
	endtask

	// every accepted result beat against the oldest prediction
	always @(posedge clk) begin
		mat_pkg::res_t want;
		if (res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				report("result beat with nothing pending", res_ch.value, '0);
			end else begin
				want = pending_results.pop_front();
				if (res_ch.value !== want.value) begin
					report("value", res_ch.value, want.value);
				end
				if (res_ch.row !== want.row) begin
					report("row", 32'(res_ch.row), 32'(want.row));
				end
				if (res_ch.col !== want.col) begin
					report("col", 32'(res_ch.col), 32'(want.col));
				end
				if (res_ch.last !== want.last) begin
					report("last", 32'(res_ch.last), 32'(want.last));
				end
			end
		end
	end

	// give up when no beat moves on any channel for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((elem_ch.valid && elem_ch.ready) || (res_ch.valid && res_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready)) begin
				idle = 0;
			end else begin
				idle++;
			end
			if (idle >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// result receiver: random stall bursts, calm stretches, one long hold-off
	// ------------------------------------------------------------------

	initial begin : receiver
		int span, k;
		res_ch.ready = 1'b0;
		forever begin
			// each stretch either never stalls or stalls at its own rate
			span    = $urandom_range(20, 120);
			rx_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 8);
			for (k = 0; k < span; k++) begin
				@(negedge clk);
				if (hold_req) begin
					res_ch.ready = 1'b0;
					for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
						@(negedge clk);
					end
					res_ch.ready = 1'b1;
					hold_req     = 1'b0;
				end else if (!quiet && rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
					res_ch.ready = 1'b0;
					repeat ($urandom_range(1, 16) - 1) @(negedge clk);
				end else begin
					res_ch.ready = 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------

	// valid stays up after the beat so back-to-back elements leave no bubble;
	// every other task that spends time lowers it at its first falling edge
	task automatic push_element(logic [31:0] x);
		@(negedge clk);
		elem_ch.valid   = 1'b1;
		elem_ch.element = x;
		@(posedge clk);
		while (elem_ch.ready !== 1'b1) begin
			@(posedge clk);
		end
		absorb_element(x);
	endtask

	task automatic maybe_pause();
		if (!quiet && tx_odds != 0 && $urandom_range(1, tx_odds) == 1) begin
			@(negedge clk);
			elem_ch.valid = 1'b0;
			repeat ($urandom_range(1, 16) - 1) @(negedge clk);
		end
	endtask

	// hold the element stream until every predicted beat has come back
	task automatic await_results();
		@(negedge clk);
		elem_ch.valid = 1'b0;
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_reg(mat_pkg::cfg_reg_t idx, logic [3:0] val);
		@(negedge clk);
		elem_ch.valid = 1'b0;
		cfg_ch.valid  = 1'b1;
		cfg_ch.index  = idx;
		cfg_ch.data   = val;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1) begin
			@(posedge clk);
		end
		apply_reg(idx, val);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// registers change only with the block drained and its last beat well behind it
	task automatic set_problem(logic [3:0] mode_data, logic [3:0] ra, logic [3:0] ca,
			logic [3:0] cb);
		await_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(mat_pkg::REG_MODE, mode_data);
		write_reg(mat_pkg::REG_ROWS_A, ra);
		write_reg(mat_pkg::REG_COLS_A, ca);
		write_reg(mat_pkg::REG_COLS_B, cb);
	endtask

	// corner words, small values around zero, or any 32-bit pattern
	function automatic logic [31:0] pick_element();
		case ($urandom_range(0, 9))
			0: begin
				return 32'h7fff_ffff;
			end
			1: begin
				return 32'h8000_0000;
			end
			2: begin
				return 32'hffff_ffff;
			end
			3: begin
				return 32'h0000_0000;
			end
			4: begin
				return 32'($urandom_range(0, 20)) - 32'd10;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	// unused upper bits of the mode write get random values too
	function automatic logic [3:0] pick_mode();
		logic [1:0] code;
		case ($urandom_range(0, 6))
			0, 1: begin
				code = mat_pkg::MODE_ADD;
			end
			2, 3: begin
				code = mat_pkg::MODE_MUL;
			end
			4, 5: begin
				code = mat_pkg::MODE_TRN;
			end
			default: begin
				code = MODE_SPARE;
			end
		endcase
		return {2'($urandom_range(0, 3)), code};
	endfunction

	function automatic logic [3:0] pick_dim(logic big);
		return big ? 4'($urandom_range(4, 15)) : 4'($urandom_range(0, 3));
	endfunction

	// one full problem of random operands; returns the element count
	task automatic send_problem(output int n);
		int i;
		n = operands_needed();
		for (i = 0; i < n; i++) begin
			maybe_pause();
			push_element(pick_element());
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// out of reset: add, 1 by 1; overflow on both ends
	task automatic test_reset_defaults();
		push_element(32'h7fff_ffff);
		push_element(32'h0000_0001);
		push_element(32'h8000_0000);
		push_element(32'h8000_0000);
	endtask

	// a register write part way through a load throws the partial problem away
	task automatic test_restart_on_write();
		push_element(32'h1234_5678);
		await_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(mat_pkg::REG_COLS_B, 4'd1);
		push_element(32'hffff_fffb);
		push_element(32'h0000_0007);
	endtask

	// 1x2 times 2x1 with products and the sum wrapping; junk in the high mode bits
	task automatic test_multiply_wrap();
		set_problem({2'b10, mat_pkg::MODE_MUL}, 4'd1, 4'd2, 4'd1);
		push_element(32'h7fff_ffff);
		push_element(32'h8000_0000);
		push_element(32'h7fff_ffff);
		push_element(32'hffff_ffff);
	endtask

	// every dimension zero, so 1x1 times 1x1
	task automatic test_zero_dims();
		set_problem({2'b00, mat_pkg::MODE_MUL}, 4'd0, 4'd0, 4'd0);
		push_element(32'hdead_beef);
		push_element(32'h0000_0003);
	endtask

	// cols_a far past the maximum clamps to eight: 1x8 turns into 8x1
	task automatic test_transpose_clamp();
		int i;
		set_problem({2'b01, mat_pkg::MODE_TRN}, 4'd1, 4'd15, 4'd15);
		for (i = 0; i < DIM_MAX; i++) begin
			push_element(pick_element());
		end
	endtask

	// the spare mode code transposes a 2x1
	task automatic test_spare_mode();
		set_problem({2'b11, MODE_SPARE}, 4'd2, 4'd1, 4'd9);
		push_element(32'h0000_0011);
		push_element(32'h8000_0022);
	endtask

	// receiver holds off while 1x1 transposes keep coming, so the block fills and
	// stalls intake; then the sender waits for a full drain before going on
	task automatic test_backpressure();
		int i;
		set_problem({2'b00, mat_pkg::MODE_TRN}, 4'd1, 4'd1, 4'd1);
		tx_odds  = 0;
		hold_req = 1'b1;
		for (i = 0; i < 24; i++) begin
			push_element(pick_element());
		end
		await_results();
		while (hold_req) begin
			@(negedge clk);
		end
		tx_odds = 3;
		for (i = 0; i < 8; i++) begin
			maybe_pause();
			push_element(pick_element());
		end
	endtask

	// random shapes and modes, mostly small; now and then a problem is cut short
	task automatic test_random_problems();
		int   sent, n, p, nprob, i, cut;
		logic big;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			big     = ($urandom_range(0, 11) == 0);
			tx_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
			set_problem(pick_mode(), pick_dim(big), pick_dim(big), pick_dim(big));
			nprob = big ? 1 : $urandom_range(1, 4);
			for (p = 0; p < nprob; p++) begin
				if ($urandom_range(0, 9) == 0 && operands_needed() > 1) begin
					// broken load, the next register write restarts it
					cut = $urandom_range(1, operands_needed() - 1);
					for (i = 0; i < cut; i++) begin
						maybe_pause();
						push_element(pick_element());
					end
					sent += cut;
					break;
				end
				send_problem(n);
				sent += n;
			end
		end
	endtask

	// closing stretch with both sides streaming flat out
	task automatic test_quiet_finish();
		int n, p;
		quiet   = 1'b1;
		tx_odds = 0;
		set_problem({2'b00, mat_pkg::MODE_ADD}, 4'd2, 4'd3, 4'd1);
		for (p = 0; p < 3; p++) begin
			send_problem(n);
		end
		set_problem({2'b00, mat_pkg::MODE_MUL}, 4'd2, 4'd2, 4'd2);
		send_problem(n);
	endtask

	initial begin
		// every input known from time zero while reset is held
		arst_n          = 1'b0;
		elem_ch.valid   = 1'b0;
		elem_ch.element = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = mat_pkg::REG_MODE;
		cfg_ch.data     = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_restart_on_write();
		test_multiply_wrap();
		test_zero_dims();
		test_transpose_clamp();
		test_spare_mode();
		test_backpressure();
		test_random_problems();
		test_quiet_finish();

		// drain, then leave room for any stray beat
		await_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (pending_results.size() != 0) begin
			report("results never seen", 32'(pending_results.size()), '0);
		end
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
